[hw/rtl/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES = 4'd4;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_TRUNC   = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXTLEN  = 6'b000100,
      PH_MASK    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [3:0] frame_opcode_out;
      logic       final_fragment;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         count;
      rsp_type [1:0]      items;
   } push_type;

endpackage
`default_nettype wire

[hw/rtl/wsd_if.sv]
// Valid/ready channel interfaces for the deframer request and result streams.
`default_nettype none
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       buffer_end;

   modport source(output valid, output rx_byte, output buffer_end, input ready);
   modport sink(input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [3:0] frame_opcode_out;
   logic       final_fragment;
   logic       frame_end;

   modport source(output valid, output kind, output data_byte, output frame_opcode_out,
                  output final_fragment, output frame_end, input ready);
   modport sink(input valid, input kind, input data_byte, input frame_opcode_out,
                input final_fragment, input frame_end, output ready);
endinterface
`default_nettype wire

[hw/rtl/websocket_client_frame_deframer_unit.sv]
// WebSocket receive-side frame deframer top level.
//
// The req_if channel takes one byte of a received buffer per request, with
// buffer_end marking the buffer's last byte. The rsp_if channel returns
// payload bytes unmasked with the frame's key, an empty-frame marker, or a
// truncation error when a buffer ends before its frame is complete.
// Each request passes through an input register and then through the parser,
// which writes zero, one or two results into a four-entry result queue.
// The results of a request are presented on rsp_if only after the request
// has been registered in the input register and its results in the queue.
// Throughput is one request per cycle while the receiver keeps up; a request
// that yields two results sends them out one at a time. The parser advances
// only when the queue has room for two results, so a stalled receiver backs
// up into the input register and then drops req_if.ready; nothing is lost.
// Reset empties the queue and the input register and leaves the parser
// waiting for the first header byte of a frame.
`default_nettype none
module websocket_client_frame_deframer_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   wsd_req_if.sink    req_if,
   wsd_rsp_if.source  rsp_if
);
   import wsd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       room;
   logic       fire;
   logic       take;
   push_type   push;

   assign fire          = in_valid_ff && room;
   assign req_if.ready  = !in_valid_ff || fire;
   assign take          = req_if.valid && req_if.ready;
   assign in_valid_in   = take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_if.rx_byte;
         in_last_ff <= req_if.buffer_end;
      end
   end

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .rx_byte    (in_byte_ff),
      .buffer_end (in_last_ff),
      .push       (push)
   );

   wsd_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_if)
   );

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && in_byte_ff == $past(in_byte_ff))
      else $error("input register lost a request while stalled");

endmodule
`default_nettype wire

[hw/rtl/wsd_parser.sv]
// Frame header parser, payload unmasking and truncation detection for one byte per cycle while fire is high.
`default_nettype none
module wsd_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             buffer_end,
   output wsd_pkg::push_type     push
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [1:0]  pidx_ff, pidx_in;
   logic [7:0]  key_ff [4];
   logic [7:0]  key_in [4];
   logic        mask_en_ff, mask_en_in;
   logic [3:0]  op_ff, op_in;
   logic        fin_ff, fin_in;

   logic        hdr_done;
   logic        hdr_zero;
   logic        hdr_from_mask;
   logic        prim_valid;
   rsp_type     prim;
   rsp_type     trunc;
   logic [1:0]  kidx;
   logic [7:0]  unmasked;

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      len_in        = len_ff;
      pidx_in       = pidx_ff;
      key_in        = key_ff;
      mask_en_in    = mask_en_ff;
      op_in         = op_ff;
      fin_in        = fin_ff;
      hdr_done      = 1'b0;
      hdr_zero      = 1'b0;
      hdr_from_mask = 1'b0;
      prim_valid    = 1'b0;
      prim          = '0;
      trunc         = '0;
      kidx          = 2'd0 - cnt_ff[1:0];
      unmasked      = rx_byte ^ (mask_en_ff ? key_ff[pidx_ff] : 8'h00);
      push          = '0;

      if (fire) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in   = rx_byte[7];
               op_in    = rx_byte[3:0];
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               mask_en_in = rx_byte[7];
               len_in     = '0;
               if (rx_byte[6:0] == LEN16_CODE) begin
                  cnt_in   = EXT16_BYTES;
                  phase_in = PH_EXTLEN;
               end else if (rx_byte[6:0] == LEN64_CODE) begin
                  cnt_in   = EXT64_BYTES;
                  phase_in = PH_EXTLEN;
               end else begin
                  len_in   = {57'd0, rx_byte[6:0]};
                  hdr_done = 1'b1;
                  hdr_zero = (rx_byte[6:0] == 7'd0);
               end
            end
            PH_EXTLEN: begin
               len_in = {len_ff[55:0], rx_byte};
               cnt_in = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  hdr_done = 1'b1;
                  hdr_zero = (len_in == 64'd0);
               end
            end
            PH_MASK: begin
               key_in[kidx] = rx_byte;
               cnt_in       = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  hdr_done      = 1'b1;
                  hdr_from_mask = 1'b1;
                  hdr_zero      = (len_ff == 64'd0);
               end
            end
            PH_PAYLOAD: begin
               pidx_in               = pidx_ff + 2'd1;
               len_in                = len_ff - 64'd1;
               prim_valid            = 1'b1;
               prim.kind             = KIND_PAYLOAD;
               prim.data_byte        = unmasked;
               prim.frame_opcode_out = op_ff;
               prim.final_fragment   = fin_ff;
               prim.frame_end        = (len_ff == 64'd1);
               if (len_ff == 64'd1) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase

         if (hdr_done) begin
            pidx_in = 2'd0;
            if (mask_en_in && !hdr_from_mask) begin
               cnt_in   = KEY_BYTES;
               phase_in = PH_MASK;
            end else if (hdr_zero) begin
               prim_valid            = 1'b1;
               prim.kind             = KIND_EMPTY;
               prim.frame_opcode_out = op_in;
               prim.final_fragment   = fin_in;
               prim.frame_end        = 1'b1;
               phase_in              = PH_DONE;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         trunc.kind             = KIND_TRUNC;
         trunc.frame_opcode_out = op_in;
         trunc.final_fragment   = fin_in;

         if (buffer_end && phase_in != PH_DONE) begin
            push.count    = prim_valid ? 2'd2 : 2'd1;
            push.items[0] = prim_valid ? prim : trunc;
            push.items[1] = trunc;
         end else if (prim_valid) begin
            push.count    = 2'd1;
            push.items[0] = prim;
         end

         // The end of a buffer always returns the parser to its idle state.
         if (buffer_end) begin
            phase_in   = PH_HDR0;
            cnt_in     = '0;
            len_in     = '0;
            pidx_in    = '0;
            key_in     = '{default: 8'h00};
            mask_en_in = 1'b0;
            op_in      = '0;
            fin_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         cnt_ff     <= '0;
         len_ff     <= '0;
         pidx_ff    <= '0;
         key_ff     <= '{default: 8'h00};
         mask_en_ff <= 1'b0;
         op_ff      <= '0;
         fin_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         len_ff     <= len_in;
         pidx_ff    <= pidx_in;
         key_ff     <= key_in;
         mask_en_ff <= mask_en_in;
         op_ff      <= op_in;
         fin_ff     <= fin_in;
      end
   end

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |-> push.count == 2'd0)
      else $error("parser pushed results without an input byte");

   a_pair_ends_trunc: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.items[1].kind == KIND_TRUNC && buffer_end)
      else $error("second result of a byte is not a truncation at buffer end");

   a_buffer_end_resets: assert property (@(posedge clock) disable iff (reset)
      fire && buffer_end |=> phase_ff == PH_HDR0 && !mask_en_ff)
      else $error("parser did not return to idle after buffer end");

endmodule
`default_nettype wire

[hw/rtl/wsd_rsp_fifo.sv]
// Four-entry result queue that takes up to two results per cycle and hands out one.
`default_nettype none
module wsd_rsp_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire wsd_pkg::push_type push,
   output logic                  room,
   wsd_rsp_if.source             rsp
);
   import wsd_pkg::*;

   rsp_type           mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;
   rsp_type           head;

   assign head  = mem_ff[rd_ptr_ff];
   assign pop   = rsp.valid && rsp.ready;
   assign room  = (count_ff <= CNT_W'(FIFO_DEPTH - 2));

   assign rsp.valid            = (count_ff != '0);
   assign rsp.kind             = head.kind;
   assign rsp.data_byte        = head.data_byte;
   assign rsp.frame_opcode_out = head.frame_opcode_out;
   assign rsp.final_fragment   = head.final_fragment;
   assign rsp.frame_end        = head.frame_end;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.items[0];
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.items[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("result queue written without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("result queue count did not drop after a lone read");

endmodule
`default_nettype wire

[sim/frame_checker.sv]
// Checker that predicts deframer results from accepted requests and compares them.
`timescale 1ns / 1ps
module frame_checker (
   input  logic clock,
   input  logic reset,
   wsd_req_if   req_mon,
   wsd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked
);
   import wsd_pkg::*;

   phase_type   phase;
   logic [3:0]  bytes_left;
   logic [63:0] frame_len;
   logic [63:0] byte_index;
   logic [7:0]  key [4];
   logic        masked;
   logic [3:0]  held_op;
   logic        held_fin;

   rsp_type expected_rsp[$];
   rsp_type want;
   int      fails = 0;
   int      seen = 0;

   assign fail_count = fails;
   assign checked = seen;

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fails++;
   endtask

   task automatic clear_parser();
      phase = PH_HDR0;
      bytes_left = '0;
      frame_len = '0;
      byte_index = '0;
      for (int i = 0; i < 4; i++) key[i] = '0;
      masked = 1'b0;
      held_op = '0;
      held_fin = 1'b0;
   endtask

   task automatic queue_result(input kind_type k, input logic [7:0] d, input logic fe);
      rsp_type r;
      r.kind = k;
      r.data_byte = d;
      r.frame_opcode_out = held_op;
      r.final_fragment = held_fin;
      r.frame_end = fe;
      expected_rsp = {expected_rsp, r};
   endtask

   task automatic start_payload();
      byte_index = '0;
      if (frame_len == 64'd0) begin
         queue_result(KIND_EMPTY, 8'h00, 1'b1);
         phase = PH_DONE;
      end else begin
         phase = PH_PAYLOAD;
      end
   endtask

   task automatic length_done();
      if (masked) begin
         bytes_left = KEY_BYTES;
         phase = PH_MASK;
      end else begin
         start_payload();
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [7:0] v;
      logic       fe;
      case (phase)
         PH_HDR0: begin
            held_fin = b[7];
            held_op = b[3:0];
            phase = PH_HDR1;
         end
         PH_HDR1: begin
            masked = b[7];
            frame_len = '0;
            if (b[6:0] == LEN16_CODE) begin
               bytes_left = EXT16_BYTES;
               phase = PH_EXTLEN;
            end else if (b[6:0] == LEN64_CODE) begin
               bytes_left = EXT64_BYTES;
               phase = PH_EXTLEN;
            end else begin
               frame_len = 64'(b[6:0]);
               length_done();
            end
         end
         PH_EXTLEN: begin
            frame_len = {frame_len[55:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0) length_done();
         end
         PH_MASK: begin
            key[2'(KEY_BYTES - bytes_left)] = b;
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0) start_payload();
         end
         PH_PAYLOAD: begin
            v = masked ? (b ^ key[byte_index[1:0]]) : b;
            byte_index = byte_index + 64'd1;
            fe = (byte_index == frame_len);
            queue_result(KIND_PAYLOAD, v, fe);
            if (fe) phase = PH_DONE;
         end
         default: ;
      endcase
      if (last) begin
         if (phase != PH_DONE) queue_result(KIND_TRUNC, 8'h00, 1'b0);
         clear_parser();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_rsp.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) decode_byte(req_mon.rx_byte, req_mon.buffer_end);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen++;
            if (expected_rsp.size() == 0) begin
               report($sformatf("result kind %0d data %02h arrived with nothing expected",
                                rsp_mon.kind, rsp_mon.data_byte));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_mon.kind !== want.kind || rsp_mon.data_byte !== want.data_byte ||
                   rsp_mon.frame_opcode_out !== want.frame_opcode_out ||
                   rsp_mon.final_fragment !== want.final_fragment ||
                   rsp_mon.frame_end !== want.frame_end) begin
                  report($sformatf({"got kind %0d data %02h op %h fin %b end %b, ",
                                    "expected kind %0d data %02h op %h fin %b end %b"},
                                   rsp_mon.kind, rsp_mon.data_byte, rsp_mon.frame_opcode_out,
                                   rsp_mon.final_fragment, rsp_mon.frame_end,
                                   want.kind, want.data_byte, want.frame_opcode_out,
                                   want.final_fragment, want.frame_end));
               end
            end
         end
      end
      pending <= expected_rsp.size();
   end
endmodule

[sim/tb.sv]
// Top-level testbench that feeds framed byte buffers to the deframer and gives the verdict.
`timescale 1ns / 1ps
module tb;
   import wsd_pkg::*;

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   wsd_req_if req_ch ();
   wsd_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int checked;

   websocket_client_frame_deframer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   frame_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   bit         idle_on;
   bit         hold_rsp;
   logic [7:0] buf_bytes[$];
   int         useful_len;
   int         sent_bytes;
   int         buffers;

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      req_ch.buffer_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_buffer();
      for (int i = 0; i < buf_bytes.size(); i++) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
      buffers++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      buf_bytes = {buf_bytes, b};
   endtask

   // Builds one buffer: mostly well-formed frames, some cut short, some pure noise.
   task automatic build_frame();
      int         shape;
      int         lt;
      int         len;
      int         npay;
      int         cut;
      int         junk;
      logic       mask;
      logic [15:0] len16;
      buf_bytes.delete();
      shape = $urandom_range(0, 9);
      if (shape == 9) begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
         useful_len = buf_bytes.size();
         return;
      end
      add_byte(8'($urandom_range(0, 255)));
      mask = 1'($urandom_range(0, 1));
      lt = $urandom_range(0, 9);
      if (lt < 6) begin
         if (shape >= 7 || $urandom_range(0, 30) == 0) len = $urandom_range(0, 125);
         else len = $urandom_range(0, 12);
         add_byte({mask, 7'(len)});
      end else if (lt < 8) begin
         if (shape >= 7) len16 = 16'($urandom_range(0, 65535));
         else len16 = 16'($urandom_range(0, 12));
         len = len16;
         add_byte({mask, LEN16_CODE});
         add_byte(len16[15:8]);
         add_byte(len16[7:0]);
      end else begin
         add_byte({mask, LEN64_CODE});
         if (shape >= 7) begin
            repeat (8) add_byte(8'($urandom_range(0, 255)));
            len = 16;
         end else begin
            len = $urandom_range(0, 12);
            repeat (7) add_byte(8'h00);
            add_byte(8'(len));
         end
      end
      if (mask) repeat (4) add_byte(8'($urandom_range(0, 255)));
      npay = (shape >= 7 && len > 16) ? 16 : len;
      repeat (npay) add_byte(8'($urandom_range(0, 255)));
      useful_len = buf_bytes.size();
      if (shape < 7) begin
         junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         repeat (junk) add_byte(8'($urandom_range(0, 255)));
      end else begin
         cut = $urandom_range(1, buf_bytes.size());
         while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
         useful_len = buf_bytes.size();
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            hold_rsp = 1'b0;
            repeat (300) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      bit held;
      bit paused;
      held = 1'b0;
      paused = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      req_ch.buffer_end <= 1'b0;
      idle_on = 1'b1;
      hold_rsp = 1'b0;
      sent_bytes = 0;
      buffers = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty unmasked frame followed by a byte past the frame end.
      buf_bytes = '{8'h81, 8'h00, 8'hff};
      send_buffer();
      // Empty masked frame.
      buf_bytes = '{8'h09, 8'h80, 8'hff, 8'h00, 8'h55, 8'haa};
      send_buffer();
      // Masked payload whose bytes use every key byte and wrap back to the first.
      buf_bytes = '{8'h82, 8'h85, 8'h12, 8'h34, 8'h56, 8'h78, 8'hff, 8'h00, 8'ha5,
                    8'h5a, 8'h3c};
      send_buffer();
      // Sixteen-bit length that is not minimally encoded.
      buf_bytes = '{8'h01, 8'h7e, 8'h00, 8'h01, 8'h3c};
      send_buffer();
      // Sixty-four-bit length with its top bit set, cut short after one payload byte.
      buf_bytes = '{8'h8f, 8'h7f, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h02, 8'h77};
      send_buffer();
      // Buffer that ends on the first header byte.
      buf_bytes = '{8'hf0};
      send_buffer();

      while (sent_bytes < 550) begin
         idle_on = (sent_bytes < 450) && ($urandom_range(0, 4) != 0);
         build_frame();
         send_buffer();
         sent_bytes += useful_len;
         if (!held && sent_bytes >= 150) begin
            held = 1'b1;
            hold_rsp = 1'b1;
         end
         if (!paused && sent_bytes >= 300) begin
            paused = 1'b1;
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end
      idle_on = 1'b0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d buffers carrying %0d frame bytes: headers, masks, extended lengths,",
               buffers, sent_bytes);
      $display("truncations and noise; %0d results were compared.", checked);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
